@@ rtl/core/dmaseq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmaseq_pkg
// Shared codes, register map constants, types and unit tables of the DMA
// address sequencer.
// ----------------------------------------------------------------------------
package dmaseq_pkg;

  localparam int REGS_PER_CH = 12;
  localparam int CH_IDX_W    = 3;
  localparam int REG_OFF_W   = 4;

  // input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // bus map
  localparam logic [15:0] ADDR_DMA_EN  = 16'h420B;
  localparam logic [15:0] ADDR_HDMA_EN = 16'h420C;
  localparam logic [15:0] ADDR_CH_LO   = 16'h4300;
  localparam logic [15:0] ADDR_CH_HI   = 16'h437F;

  // register offsets within a channel
  localparam logic [REG_OFF_W-1:0] REG_PARAM   = 4'd0;
  localparam logic [REG_OFF_W-1:0] REG_B_ADDR  = 4'd1;
  localparam logic [REG_OFF_W-1:0] REG_A_LO    = 4'd2;
  localparam logic [REG_OFF_W-1:0] REG_A_HI    = 4'd3;
  localparam logic [REG_OFF_W-1:0] REG_A_BANK  = 4'd4;
  localparam logic [REG_OFF_W-1:0] REG_CNT_LO  = 4'd5;
  localparam logic [REG_OFF_W-1:0] REG_CNT_HI  = 4'd6;
  localparam logic [REG_OFF_W-1:0] REG_SPARE   = 4'd11;
  localparam logic [REG_OFF_W-1:0] REG_ALIAS   = 4'd15;

  // A offset step codes
  localparam logic [1:0] STEP_INC = 2'd0;
  localparam logic [1:0] STEP_DEC = 2'd2;

  typedef logic [REGS_PER_CH-1:0][7:0] row_t;

  typedef struct packed {
    logic                   en;
    logic [CH_IDX_W-1:0]    row;
    logic [REGS_PER_CH-1:0] be;
    row_t                   data;
  } wr_req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // bytes per transfer unit for each mode
  function automatic logic [2:0] unit_size(input logic [2:0] mode);
    logic [2:0] s;
    case (mode)
      3'd0:    s = 3'd1;
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd2;
      3'd3:    s = 3'd4;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd2;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  // B-bus address offset of byte i of a unit
  function automatic logic [1:0] b_offset(input logic [2:0] mode, input logic [1:0] i);
    logic [1:0] o;
    case (mode)
      3'd1, 3'd5: o = {1'b0, i[0]};
      3'd3, 3'd7: o = {1'b0, i[1]};
      3'd4:       o = i;
      default:    o = 2'd0;
    endcase
    return o;
  endfunction

endpackage

@@ rtl/core/dmaseq_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmaseq_regs
// Channel register store: one row of bytes per channel, byte-enable writes,
// registered whole-row reads. Bytes never written read 0xFF.
// ----------------------------------------------------------------------------
module dmaseq_regs #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [dmaseq_pkg::CH_IDX_W-1:0]       rd_row,
  output dmaseq_pkg::row_t                      rd_data,
  input  dmaseq_pkg::wr_req_t                   wr
);

  localparam int ROW_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NREG  = dmaseq_pkg::REGS_PER_CH;

  logic [7:0]      mem [NUM_CHANNELS][NREG];
  logic [NREG-1:0] vld [NUM_CHANNELS];
  logic [7:0]      rd_q [NREG];
  logic [NREG-1:0] rd_vld;

  always_ff @(posedge clk) begin
    for (int j = 0; j < NREG; j++) begin
      if (wr.en && wr.be[j]) begin
        mem[wr.row[ROW_W-1:0]][j] <= wr.data[j];
      end
    end
    if (rd_en) begin
      for (int j = 0; j < NREG; j++) begin
        rd_q[j] <= mem[rd_row[ROW_W-1:0]][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        vld[c] <= '0;
      end
      rd_vld <= '0;
    end else begin
      if (wr.en) begin
        vld[wr.row[ROW_W-1:0]] <= vld[wr.row[ROW_W-1:0]] | wr.be;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_row[ROW_W-1:0]];
      end
    end
  end

  // unwritten bytes hold their reset value
  always_comb begin
    for (int j = 0; j < NREG; j++) begin
      rd_data[j] = rd_vld[j] ? rd_q[j] : 8'hFF;
    end
  end

endmodule

@@ rtl/core/eight_channel_dma_address_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_channel_dma_address_sequencer
// General-purpose DMA address sequencer behind a byte register bus.
// ----------------------------------------------------------------------------
// One item at a time. A register write gives no result. A register read
// passes through the row read from the channel store, then the result
// register. A tick reads the row, then gives one result per byte of a unit
// of 1 to 4 bytes; one that finds no enabled channel, or a zero byte count,
// gives one result. The count and A offset are written back to the store
// as the lookup state is left, and the byte addresses then leave one per
// cycle, unless the consumer stalls, through the output register, which a
// stalled consumer holds. The store needs no clearing pass after reset.
module eight_channel_dma_address_sequencer #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] port_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        read_valid,
  output logic [7:0]  read_data,
  output logic        busy_res,
  output logic        transfer_valid,
  output logic [2:0]  channel,
  output logic [7:0]  a_bank,
  output logic [15:0] a_offset,
  output logic [7:0]  b_address,
  output logic        b_to_a,
  output logic        last
);

  localparam int NREG = dmaseq_pkg::REGS_PER_CH;

  dmaseq_pkg::state_t  state;
  dmaseq_pkg::row_t    row;
  dmaseq_pkg::wr_req_t wr;

  logic [7:0] dma_mask;
  logic [7:0] hdma_mask;

  logic in_fire, slot_free;

  // address decode
  logic [3:0] dec_off;
  logic       dec_hit;

  // channel pick
  logic       pick_found;
  logic [2:0] pick_ch;

  // item held through the lookup
  logic [1:0] it_kind;
  logic       it_hit;
  logic [3:0] it_off;
  logic [2:0] it_ch;
  logic       it_found;

  // lookup
  logic [2:0]  lk_mode, lk_size, lk_n;
  logic [1:0]  lk_step;
  logic [15:0] lk_count, lk_count_new, lk_aoff, lk_aoff_fin;
  logic        lk_tick_busy, lk_single, lk_leave;

  // emit
  logic [1:0]  em_i, em_nm1, em_step;
  logic [2:0]  em_mode, em_ch;
  logic [15:0] em_aoff;
  logic [7:0]  em_bank, em_bbase;
  logic        em_dir, em_load, em_last;

  assign in_ready  = (state == dmaseq_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    dec_off = port_address[3:0];
    if (dec_off == dmaseq_pkg::REG_ALIAS) begin
      dec_off = dmaseq_pkg::REG_SPARE;
    end
    dec_hit = (port_address >= dmaseq_pkg::ADDR_CH_LO)
           && (port_address <= dmaseq_pkg::ADDR_CH_HI)
           && ({1'b0, port_address[6:4]} < 4'(NUM_CHANNELS))
           && (dec_off <= dmaseq_pkg::REG_SPARE);
  end

  // lowest enabled channel wins
  always_comb begin
    pick_found = 1'b0;
    pick_ch    = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (dma_mask[i]) begin
        pick_found = 1'b1;
        pick_ch    = 3'(i);
      end
    end
  end

  // unit size, remaining count and final A offset of the served channel
  always_comb begin
    lk_mode  = row[dmaseq_pkg::REG_PARAM][2:0];
    lk_step  = row[dmaseq_pkg::REG_PARAM][4:3];
    lk_size  = dmaseq_pkg::unit_size(lk_mode);
    lk_count = {row[dmaseq_pkg::REG_CNT_HI], row[dmaseq_pkg::REG_CNT_LO]};
    lk_aoff  = {row[dmaseq_pkg::REG_A_HI], row[dmaseq_pkg::REG_A_LO]};
    if (lk_count <= {13'd0, lk_size}) begin
      lk_n         = lk_count[2:0];
      lk_count_new = '0;
    end else begin
      lk_n         = lk_size;
      lk_count_new = lk_count - {13'd0, lk_size};
    end
    case (lk_step)
      dmaseq_pkg::STEP_INC: lk_aoff_fin = lk_aoff + {13'd0, lk_n};
      dmaseq_pkg::STEP_DEC: lk_aoff_fin = lk_aoff - {13'd0, lk_n};
      default:              lk_aoff_fin = lk_aoff;
    endcase
    lk_tick_busy = (it_kind == dmaseq_pkg::KIND_TICK) && it_found;
    lk_single    = !lk_tick_busy || (lk_n == 3'd0);
    lk_leave     = (state == dmaseq_pkg::ST_LOOK) && (!lk_single || slot_free);
  end

  // store write port: register writes from idle, write-back after lookup
  always_comb begin
    wr      = '0;
    wr.data = '0;
    if (lk_leave && lk_tick_busy) begin
      wr.en  = 1'b1;
      wr.row = it_ch;
      wr.be[dmaseq_pkg::REG_A_LO]   = 1'b1;
      wr.be[dmaseq_pkg::REG_A_HI]   = 1'b1;
      wr.be[dmaseq_pkg::REG_CNT_LO] = 1'b1;
      wr.be[dmaseq_pkg::REG_CNT_HI] = 1'b1;
      wr.data[dmaseq_pkg::REG_A_LO]   = lk_aoff_fin[7:0];
      wr.data[dmaseq_pkg::REG_A_HI]   = lk_aoff_fin[15:8];
      wr.data[dmaseq_pkg::REG_CNT_LO] = lk_count_new[7:0];
      wr.data[dmaseq_pkg::REG_CNT_HI] = lk_count_new[15:8];
    end else if (in_fire && (kind == dmaseq_pkg::KIND_WRITE) && dec_hit) begin
      wr.en  = 1'b1;
      wr.row = port_address[6:4];
      wr.be[dec_off] = 1'b1;
      for (int j = 0; j < NREG; j++) begin
        wr.data[j] = write_data;
      end
    end
  end

  dmaseq_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire && ((kind == dmaseq_pkg::KIND_READ) || (kind == dmaseq_pkg::KIND_TICK))),
    .rd_row  ((kind == dmaseq_pkg::KIND_READ) ? port_address[6:4] : pick_ch),
    .rd_data (row),
    .wr      (wr)
  );

  assign em_load = (state == dmaseq_pkg::ST_EMIT) && slot_free;
  assign em_last = (em_i == em_nm1);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dmaseq_pkg::ST_IDLE;
      dma_mask  <= '0;
      hdma_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((lk_leave && lk_single) || em_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        dmaseq_pkg::ST_IDLE: begin
          if (in_fire) begin
            case (kind)
              dmaseq_pkg::KIND_WRITE: begin
                if (port_address == dmaseq_pkg::ADDR_DMA_EN) begin
                  dma_mask <= write_data;
                end else if (port_address == dmaseq_pkg::ADDR_HDMA_EN) begin
                  hdma_mask <= write_data;
                end
              end
              dmaseq_pkg::KIND_READ, dmaseq_pkg::KIND_TICK: begin
                state <= dmaseq_pkg::ST_LOOK;
              end
              default: begin
                state <= dmaseq_pkg::ST_IDLE;
              end
            endcase
          end
        end
        dmaseq_pkg::ST_LOOK: begin
          if (lk_leave) begin
            if (lk_single) begin
              state <= dmaseq_pkg::ST_IDLE;
            end else begin
              state <= dmaseq_pkg::ST_EMIT;
            end
            if (lk_tick_busy && (lk_count_new == '0)) begin
              dma_mask[it_ch] <= 1'b0;
            end
          end
        end
        dmaseq_pkg::ST_EMIT: begin
          if (em_load && em_last) begin
            state <= dmaseq_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= dmaseq_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // item, emit and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_kind  <= kind;
      it_hit   <= dec_hit;
      it_off   <= dec_off;
      it_ch    <= pick_ch;
      it_found <= pick_found;
    end
    if (lk_leave) begin
      if (lk_single) begin
        read_valid     <= (it_kind == dmaseq_pkg::KIND_READ) && it_hit;
        read_data      <= ((it_kind == dmaseq_pkg::KIND_READ) && it_hit) ? row[it_off] : 8'd0;
        busy_res       <= lk_tick_busy;
        transfer_valid <= 1'b0;
        channel        <= lk_tick_busy ? it_ch : 3'd0;
        a_bank         <= '0;
        a_offset       <= '0;
        b_address      <= '0;
        b_to_a         <= 1'b0;
        last           <= 1'b1;
      end
      // hold the unit for the byte-by-byte pass
      em_i     <= '0;
      em_nm1   <= 2'(lk_n - 3'd1);
      em_mode  <= lk_mode;
      em_step  <= lk_step;
      em_ch    <= it_ch;
      em_aoff  <= lk_aoff;
      em_bank  <= row[dmaseq_pkg::REG_A_BANK];
      em_bbase <= row[dmaseq_pkg::REG_B_ADDR];
      em_dir   <= row[dmaseq_pkg::REG_PARAM][7];
    end
    if (em_load) begin
      read_valid     <= 1'b0;
      read_data      <= '0;
      busy_res       <= 1'b1;
      transfer_valid <= 1'b1;
      channel        <= em_ch;
      a_bank         <= em_bank;
      a_offset       <= em_aoff;
      b_address      <= em_bbase + {6'd0, dmaseq_pkg::b_offset(em_mode, em_i)};
      b_to_a         <= em_dir;
      last           <= em_last;
      em_i           <= em_i + 2'd1;
      case (em_step)
        dmaseq_pkg::STEP_INC: em_aoff <= em_aoff + 16'd1;
        dmaseq_pkg::STEP_DEC: em_aoff <= em_aoff - 16'd1;
        default:              em_aoff <= em_aoff;
      endcase
    end
  end

endmodule
